// ===== rtl/core/uvdec_pkg.sv =====
// Shared types and constants for the unsigned LEB128 varint stream decoder.
`default_nettype none

package uvdec_pkg;

  // Target width selection held in the mode register.
  localparam logic [1:0] ModeU64 = 2'd0;
  localparam logic [1:0] ModeU32 = 2'd1;
  localparam logic [1:0] ModeS32 = 2'd2;

  // Byte limits and largest final byte for each target.
  localparam logic [3:0] MaxBytesU64 = 4'd10;
  localparam logic [3:0] MaxBytes32  = 4'd5;
  localparam logic [6:0] FinalMaxU64 = 7'd1;
  localparam logic [6:0] FinalMaxU32 = 7'd15;
  localparam logic [6:0] FinalMaxS32 = 7'd7;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusTruncated = 2'd1,
    StatusTooBig    = 2'd2,
    StatusRsvd      = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_buffer;
  } in_word_t;

  typedef struct packed {
    logic [63:0] decoded_value;
    logic [3:0]  byte_count;
    status_e     status;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/uvarint_stream_decoder_core.sv =====
// Unsigned LEB128 varint stream decoder: one encoded byte per word in, one result per varint out.
`default_nettype none

// Takes one byte per cycle and returns one result word for each varint that ends, overflows
// its target or is cut off by the end of the buffer; continuation bytes give no result. Each
// byte is decoded in the cycle it is accepted (a 7-bit group shift into the 64-bit accumulator
// plus limit compares) and the result lands in the output register, so the block sustains one
// byte per cycle while the output is not stalled. Input is stalled only while a result sits in the
// output register and the consumer stalls it. Write the width mode only while the block is idle.
module uvarint_stream_decoder_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire uvdec_pkg::in_word_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output uvdec_pkg::out_word_t      out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_wdata_i
);

  logic [1:0]  mode_q;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  group_q, group_d;
  logic        out_valid_q, out_valid_d;
  uvdec_pkg::out_word_t out_data_q, out_data_d;

  logic        in_accept;
  logic        emit;
  logic [3:0]  max_bytes;
  logic [6:0]  final_max;
  logic [6:0]  shamt;
  logic [63:0] acc_merged;
  logic [3:0]  group_next;
  logic [6:0]  low_bits;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign low_bits   = in_data_i.data_byte[6:0];

  always_comb begin
    unique case (mode_q)
      uvdec_pkg::ModeU32: begin
        max_bytes = uvdec_pkg::MaxBytes32;
        final_max = uvdec_pkg::FinalMaxU32;
      end
      uvdec_pkg::ModeS32: begin
        max_bytes = uvdec_pkg::MaxBytes32;
        final_max = uvdec_pkg::FinalMaxS32;
      end
      default: begin
        max_bytes = uvdec_pkg::MaxBytesU64;
        final_max = uvdec_pkg::FinalMaxU64;
      end
    endcase
  end

  // 7 * group, at most 63
  assign shamt      = {group_q, 3'b000} - {3'b000, group_q};
  assign acc_merged = acc_q | ({57'd0, low_bits} << shamt);
  assign group_next = group_q + 4'd1;

  always_comb begin
    emit       = 1'b0;
    out_data_d = out_data_q;
    acc_d      = acc_q;
    group_d    = group_q;
    if (in_accept) begin
      emit                  = 1'b1;
      out_data_d.decoded_value = 64'd0;
      out_data_d.byte_count    = group_next;
      out_data_d.status        = uvdec_pkg::StatusTooBig;
      if (group_q >= max_bytes) begin
        // left over from a mode change mid-value: report too big
        emit = 1'b1;
      end else if (!in_data_i.data_byte[7]) begin
        if (group_q == max_bytes - 4'd1 && low_bits > final_max) begin
          out_data_d.status = uvdec_pkg::StatusTooBig;
        end else begin
          out_data_d.decoded_value = acc_merged;
          out_data_d.status        = uvdec_pkg::StatusOk;
        end
      end else if (group_next == max_bytes) begin
        out_data_d.status = uvdec_pkg::StatusTooBig;
      end else if (in_data_i.last_in_buffer) begin
        out_data_d.status = uvdec_pkg::StatusTruncated;
      end else begin
        // continuation: hold partial value, no result
        emit    = 1'b0;
        acc_d   = acc_merged;
        group_d = group_next;
      end
      if (emit) begin
        acc_d   = 64'd0;
        group_d = 4'd0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= uvdec_pkg::ModeU64;
      acc_q       <= 64'd0;
      group_q     <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      acc_q       <= acc_d;
      group_q     <= group_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_err_value_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.status != uvdec_pkg::StatusOk |-> out_data_q.decoded_value == 64'd0)
    else $error("error result carries a nonzero value");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.byte_count != 4'd0 && out_data_q.byte_count <= 4'd10)
    else $error("byte count out of range");

  a_group_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_q <= 4'd9)
    else $error("group index beyond ten bytes");

  a_end_byte_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_data_i.data_byte[7] |=> out_valid_q && group_q == 4'd0 && acc_q == 64'd0)
    else $error("terminating byte did not produce a result and clear state");

  a_no_result_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.status != uvdec_pkg::StatusRsvd)
    else $error("reserved status code on output");

endmodule

`default_nettype wire
